// ===== hw/rtl/hwcd_pkg.sv =====
package hwcd_pkg;

   // Input item modes
   localparam logic [1:0] MODE_REF   = 2'd0;
   localparam logic [1:0] MODE_QRY   = 2'd1;
   localparam logic [1:0] MODE_CHECK = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   // Result status codes
   localparam logic [1:0] STAT_LOADED  = 2'd0;
   localparam logic [1:0] STAT_CHECKED = 2'd1;
   localparam logic [1:0] STAT_BORDER  = 2'd2;

   // Register indexes (byte address 4 * index)
   localparam logic [2:0] REG_ROWS   = 3'd0;
   localparam logic [2:0] REG_COLS   = 3'd1;
   localparam logic [2:0] REG_XSLIDE = 3'd2;
   localparam logic [2:0] REG_YSLIDE = 3'd3;
   localparam logic [2:0] REG_RADIUS = 3'd4;
   localparam logic [2:0] REG_THRESH = 3'd5;

   typedef struct packed {
      logic [5:0]  grid_rows;
      logic [5:0]  grid_cols;
      logic [2:0]  x_slide;
      logic [2:0]  y_slide;
      logic [1:0]  window_radius;
      logic [25:0] match_threshold;
   } cfg_type;

   // One window read: cell offset inside the window, window offset, dimension
   typedef struct packed {
      logic       valid;
      logic [2:0] i;
      logic [2:0] j;
      logic [3:0] wa;
      logic [3:0] wb;
      logic [5:0] d;
      logic       first;
      logic       last;
      logic       wlast;
   } cmd_type;

   typedef struct packed {
      logic    accept;
      logic    load_ref;
      logic    load_qry;
      logic    win_start;
      cmd_type cmd;
   } ctl_type;

   typedef struct packed {
      logic border_ok;
      logic win_done;
      logic found;
   } stat_type;

endpackage

// ===== hw/rtl/hwcd_ram.sv =====
module hwcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hwcd_ctrl.sv =====
module hwcd_ctrl #(
   parameter int DIMS = 36
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_mode,
   input  logic               rsp_stall,
   input  hwcd_pkg::cfg_type  cfg,
   input  hwcd_pkg::stat_type stat,
   output hwcd_pkg::ctl_type  ctl,
   output logic               req_stall,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic               rsp_mismatch
);

   typedef enum logic [1:0] {ST_IDLE, ST_START, ST_ISSUE, ST_WAIT} state_type;

   state_type  state_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic       rsp_mismatch_ff;
   logic [2:0] i_ff, j_ff;
   logic [3:0] wa_ff, wb_ff;
   logic [5:0] d_ff;

   logic       accept;
   logic [2:0] span;
   logic       j_end, i_end, d_end;

   assign span   = {cfg.window_radius, 1'b0};
   assign j_end  = (j_ff == span);
   assign i_end  = (i_ff == span);
   assign d_end  = (d_ff == 6'(DIMS - 1));
   assign req_stall = !((state_ff == ST_IDLE) && !rsp_valid_ff);
   assign accept    = req_valid && !req_stall;

   // Commands to the datapath
   always_comb begin
      ctl.accept        = accept;
      ctl.load_ref      = accept && (req_mode == hwcd_pkg::MODE_REF);
      ctl.load_qry      = accept && (req_mode == hwcd_pkg::MODE_QRY);
      ctl.win_start     = (state_ff == ST_START);
      ctl.cmd.valid     = (state_ff == ST_ISSUE);
      ctl.cmd.i         = i_ff;
      ctl.cmd.j         = j_ff;
      ctl.cmd.wa        = wa_ff;
      ctl.cmd.wb        = wb_ff;
      ctl.cmd.d         = d_ff;
      ctl.cmd.first     = (i_ff == 3'd0) && (j_ff == 3'd0);
      ctl.cmd.last      = i_end && j_end;
      ctl.cmd.wlast     = i_end && j_end && d_end;
   end

   // Sequence the window walk and hold the result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         rsp_status_ff   <= hwcd_pkg::STAT_LOADED;
         rsp_mismatch_ff <= 1'b0;
         i_ff  <= '0;
         j_ff  <= '0;
         wa_ff <= '0;
         wb_ff <= '0;
         d_ff  <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_mode == hwcd_pkg::MODE_CHECK) begin
                     if (stat.border_ok) begin
                        wa_ff    <= '0;
                        wb_ff    <= '0;
                        state_ff <= ST_START;
                     end else begin
                        rsp_valid_ff    <= 1'b1;
                        rsp_status_ff   <= hwcd_pkg::STAT_BORDER;
                        rsp_mismatch_ff <= 1'b0;
                     end
                  end else begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_status_ff   <= hwcd_pkg::STAT_LOADED;
                     rsp_mismatch_ff <= 1'b0;
                  end
               end
            end
            ST_START: begin
               i_ff     <= '0;
               j_ff     <= '0;
               d_ff     <= '0;
               state_ff <= ST_ISSUE;
            end
            ST_ISSUE: begin
               // advance column, then row, then dimension
               if (!j_end) begin
                  j_ff <= j_ff + 3'd1;
               end else begin
                  j_ff <= '0;
                  if (!i_end) begin
                     i_ff <= i_ff + 3'd1;
                  end else begin
                     i_ff <= '0;
                     if (!d_end) begin
                        d_ff <= d_ff + 6'd1;
                     end else begin
                        state_ff <= ST_WAIT;
                     end
                  end
               end
            end
            ST_WAIT: begin
               if (stat.win_done) begin
                  priority if (stat.found) begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_status_ff   <= hwcd_pkg::STAT_CHECKED;
                     rsp_mismatch_ff <= 1'b0;
                     state_ff        <= ST_IDLE;
                  end else if (wb_ff != {cfg.x_slide, 1'b0}) begin
                     wb_ff    <= wb_ff + 4'd1;
                     state_ff <= ST_START;
                  end else if (wa_ff != {cfg.y_slide, 1'b0}) begin
                     wb_ff    <= '0;
                     wa_ff    <= wa_ff + 4'd1;
                     state_ff <= ST_START;
                  end else begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_status_ff   <= hwcd_pkg::STAT_CHECKED;
                     rsp_mismatch_ff <= 1'b1;
                     state_ff        <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_mismatch = rsp_mismatch_ff;

endmodule

// ===== hw/rtl/hwcd_dpath.sv =====
module hwcd_dpath #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int DIMS       = 36,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_mode,
   input  logic [4:0]            req_cell_row,
   input  logic [4:0]            req_cell_col,
   input  logic [5:0]            req_dim_index,
   input  logic [VALUE_BITS-1:0] req_feature_value,
   input  hwcd_pkg::cfg_type     cfg,
   input  hwcd_pkg::ctl_type     ctl,
   output hwcd_pkg::stat_type    stat,
   output logic [7:0]            rsp_pixel_x,
   output logic [7:0]            rsp_pixel_y
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS * DIMS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RB    = $clog2(MAX_ROWS);
   localparam int CB    = $clog2(MAX_COLS);
   localparam int ACCW  = VALUE_BITS + 6;
   localparam int SADW  = ACCW + 6;
   localparam int CMPW  = (SADW > 26) ? SADW : 26;

   // Border check and load address
   logic [7:0] rows_eff, cols_eff;
   logic [3:0] lim_y, lim_x;
   logic       in_range;
   logic [AW-1:0] wr_addr;

   always_comb begin
      rows_eff = (8'(cfg.grid_rows) > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : 8'(cfg.grid_rows);
      cols_eff = (8'(cfg.grid_cols) > 8'(MAX_COLS)) ? 8'(MAX_COLS) : 8'(cfg.grid_cols);
      lim_y    = 4'(cfg.y_slide) + 4'(cfg.window_radius);
      lim_x    = 4'(cfg.x_slide) + 4'(cfg.window_radius);
      stat.border_ok = (5'(lim_y) <= req_cell_row) &&
                       (9'(req_cell_row) + 9'(lim_y) < 9'(rows_eff)) &&
                       (5'(lim_x) <= req_cell_col) &&
                       (9'(req_cell_col) + 9'(lim_x) < 9'(cols_eff));
      in_range = (32'(req_cell_row) < MAX_ROWS) && (32'(req_cell_col) < MAX_COLS) &&
                 (32'(req_dim_index) < DIMS);
      wr_addr  = AW'((AW'(req_cell_row) * AW'(MAX_COLS) + AW'(req_cell_col)) * AW'(DIMS)
                     + AW'(req_dim_index));
   end

   // Latch the checked cell and the pixel fields
   logic [4:0] row_ff, col_ff;
   logic [7:0] pix_x_ff, pix_y_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         row_ff <= req_cell_row;
         col_ff <= req_cell_col;
         if (req_mode == hwcd_pkg::MODE_CHECK) begin
            pix_x_ff <= {req_cell_col, 3'b100};
            pix_y_ff <= {req_cell_row, 3'b100};
         end else begin
            pix_x_ff <= '0;
            pix_y_ff <= '0;
         end
      end
   end

   assign rsp_pixel_x = pix_x_ff;
   assign rsp_pixel_y = pix_y_ff;

   // Stage 1: cell coordinates for the reference and query reads
   hwcd_pkg::cmd_type f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff;
   logic [RB-1:0] rr_ff, qr_ff;
   logic [CB-1:0] rc_ff, qc_ff;
   logic [AW-1:0] ra_ff, qa_ff;

   always_ff @(posedge clock) begin
      rr_ff <= RB'(row_ff) - RB'(cfg.window_radius) + RB'(ctl.cmd.i);
      rc_ff <= CB'(col_ff) - CB'(cfg.window_radius) + CB'(ctl.cmd.j);
      qr_ff <= RB'(row_ff) - RB'(cfg.y_slide) - RB'(cfg.window_radius)
               + RB'(ctl.cmd.wa) + RB'(ctl.cmd.i);
      qc_ff <= CB'(col_ff) - CB'(cfg.x_slide) - CB'(cfg.window_radius)
               + CB'(ctl.cmd.wb) + CB'(ctl.cmd.j);
      // Stage 2: linear store addresses
      ra_ff <= AW'((AW'(rr_ff) * AW'(MAX_COLS) + AW'(rc_ff)) * AW'(DIMS) + AW'(f1_ff.d));
      qa_ff <= AW'((AW'(qr_ff) * AW'(MAX_COLS) + AW'(qc_ff)) * AW'(DIMS) + AW'(f1_ff.d));
   end

   // Stores
   logic [VALUE_BITS-1:0] ref_data, qry_data;

   hwcd_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ref_ram (
      .clock   (clock),
      .wr_en   (ctl.load_ref && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_feature_value),
      .rd_addr (ra_ff),
      .rd_data (ref_data)
   );

   hwcd_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_qry_ram (
      .clock   (clock),
      .wr_en   (ctl.load_qry && in_range),
      .wr_addr (wr_addr),
      .wr_data (req_feature_value),
      .rd_addr (qa_ff),
      .rd_data (qry_data)
   );

   // Stages 3 to 6: window sums, difference, sum of differences, decision
   logic [ACCW-1:0] acc_r_ff, acc_q_ff, diff_ff;
   logic [SADW-1:0] sad_ff;
   logic            ref_nz_ff, qry_nz_ff, done_ff, found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff <= '0;
         f2_ff <= '0;
         f3_ff <= '0;
         f4_ff <= '0;
         f5_ff <= '0;
         f6_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         f1_ff <= ctl.cmd;
         f2_ff <= f1_ff;
         f3_ff <= f2_ff;
         f4_ff <= f3_ff;
         f5_ff <= f4_ff;
         f6_ff <= f5_ff;
         done_ff <= f6_ff.valid && f6_ff.wlast;
      end
   end

   always_ff @(posedge clock) begin
      if (f3_ff.valid) begin
         acc_r_ff <= (f3_ff.first ? '0 : acc_r_ff) + ACCW'(ref_data);
         acc_q_ff <= (f3_ff.first ? '0 : acc_q_ff) + ACCW'(qry_data);
      end
      if (f4_ff.valid && f4_ff.last) begin
         diff_ff <= (acc_r_ff > acc_q_ff) ? acc_r_ff - acc_q_ff : acc_q_ff - acc_r_ff;
      end
      if (ctl.win_start) begin
         sad_ff    <= '0;
         ref_nz_ff <= 1'b0;
         qry_nz_ff <= 1'b0;
      end else begin
         if (f4_ff.valid && f4_ff.last) begin
            ref_nz_ff <= ref_nz_ff || (acc_r_ff != '0);
            qry_nz_ff <= qry_nz_ff || (acc_q_ff != '0);
         end
         if (f5_ff.valid && f5_ff.last) begin
            sad_ff <= sad_ff + SADW'(diff_ff);
         end
      end
      if (f6_ff.valid && f6_ff.wlast) begin
         found_ff <= (!ref_nz_ff && !qry_nz_ff) ||
                     (CMPW'(sad_ff) < CMPW'(cfg.match_threshold));
      end
   end

   assign stat.win_done = done_ff;
   assign stat.found    = found_ff;

endmodule

// ===== hw/rtl/hog_window_change_detector.sv =====
// Load items: result beat in the cycle after acceptance.
// Check items outside the border: result in the cycle after acceptance.
// Check items: each query window visited costs DIMS * (2 * radius + 1)^2 reads of each store,
// at one read per cycle of each store; up to (2*x_slide+1)*(2*y_slide+1) windows.
// One item at a time; the next is accepted once the result beat is taken.
// Reset (synchronous) restores register defaults and control; stores are not cleared.
module hog_window_change_detector #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int DIMS       = 36,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_mode,
   input  logic [4:0]            req_cell_row,
   input  logic [4:0]            req_cell_col,
   input  logic [5:0]            req_dim_index,
   input  logic [VALUE_BITS-1:0] req_feature_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_status,
   output logic                  rsp_mismatch,
   output logic [7:0]            rsp_pixel_x,
   output logic [7:0]            rsp_pixel_y,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   hwcd_pkg::cfg_type  cfg_ff;
   hwcd_pkg::ctl_type  ctl;
   hwcd_pkg::stat_type stat;

   assign pready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_rows       <= 6'd32;
         cfg_ff.grid_cols       <= 6'd32;
         cfg_ff.x_slide         <= 3'd1;
         cfg_ff.y_slide         <= 3'd1;
         cfg_ff.window_radius   <= 2'd1;
         cfg_ff.match_threshold <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[4:2])
            hwcd_pkg::REG_ROWS:   cfg_ff.grid_rows       <= pwdata[5:0];
            hwcd_pkg::REG_COLS:   cfg_ff.grid_cols       <= pwdata[5:0];
            hwcd_pkg::REG_XSLIDE: cfg_ff.x_slide         <= pwdata[2:0];
            hwcd_pkg::REG_YSLIDE: cfg_ff.y_slide         <= pwdata[2:0];
            hwcd_pkg::REG_RADIUS: cfg_ff.window_radius   <= pwdata[1:0];
            hwcd_pkg::REG_THRESH: cfg_ff.match_threshold <= pwdata[25:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[4:2])
         hwcd_pkg::REG_ROWS:   prdata = 32'(cfg_ff.grid_rows);
         hwcd_pkg::REG_COLS:   prdata = 32'(cfg_ff.grid_cols);
         hwcd_pkg::REG_XSLIDE: prdata = 32'(cfg_ff.x_slide);
         hwcd_pkg::REG_YSLIDE: prdata = 32'(cfg_ff.y_slide);
         hwcd_pkg::REG_RADIUS: prdata = 32'(cfg_ff.window_radius);
         hwcd_pkg::REG_THRESH: prdata = 32'(cfg_ff.match_threshold);
         default:              prdata = '0;
      endcase
   end

   hwcd_ctrl #(.DIMS(DIMS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_mode     (req_mode),
      .rsp_stall    (rsp_stall),
      .cfg          (cfg_ff),
      .stat         (stat),
      .ctl          (ctl),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_mismatch (rsp_mismatch)
   );

   hwcd_dpath #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .DIMS       (DIMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_cell_row      (req_cell_row),
      .req_cell_col      (req_cell_col),
      .req_dim_index     (req_dim_index),
      .req_feature_value (req_feature_value),
      .cfg               (cfg_ff),
      .ctl               (ctl),
      .stat              (stat),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y)
   );

endmodule

// ===== hw/rtl/hwcd_checker.sv =====
module hwcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_mismatch,
   input logic [7:0] rsp_pixel_x,
   input logic [7:0] rsp_pixel_y
);

   // Hold a stalled result beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_pixel_x))
      else $error("stalled result beat changed");

   // No new item while a result beat waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while result pending");

   // Load results carry no pixel position and no mismatch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == hwcd_pkg::STAT_LOADED) |->
         !rsp_mismatch && (rsp_pixel_x == 8'd0) && (rsp_pixel_y == 8'd0))
      else $error("load result with nonzero fields");

   // Border results never mismatch and no unknown status code appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= hwcd_pkg::STAT_BORDER) &&
         !((rsp_status == hwcd_pkg::STAT_BORDER) && rsp_mismatch))
      else $error("bad result status");

endmodule

bind hog_window_change_detector hwcd_checker u_hwcd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_status   (rsp_status),
   .rsp_mismatch (rsp_mismatch),
   .rsp_pixel_x  (rsp_pixel_x),
   .rsp_pixel_y  (rsp_pixel_y)
);
